// ----- rtl/swm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sliding window median filter.
// No dependencies; imported by the controller and the datapath.
package swm_pkg;

   // Width of the window size control register.
   localparam int CSR_WIDTH = 7;

   // Read address selects for the sorted store.
   localparam logic [1:0] RD_IDX      = 2'd0;
   localparam logic [1:0] RD_IDX_NEXT = 2'd1;
   localparam logic [1:0] RD_IDX_PREV = 2'd2;
   localparam logic [1:0] RD_RANK     = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;          // latch a new sample and clear the index
      logic       cfg_wr;          // take a new window size, restart the fill
      logic [1:0] rd_sel;          // sorted store read address select
      logic       wr_en;           // write the sorted store at the index
      logic       wr_key;          // write data is the new sample, else read data
      logic       idx_inc;
      logic       idx_dec;
      logic       idx_load_count;
      logic       count_inc;
      logic       count_dec;
      logic       ring_wr;         // write the ring and advance its pointer
      logic       load_rsp;        // load the output register from read data
   } swm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;       // the window holds all of its samples
      logic hit;        // sorted read data equals the oldest sample
      logic idx_last;   // index plus one reaches the count
      logic idx_zero;
      logic greater;    // sorted read data is above the new sample
      logic rsp_free;   // output register can take a result this cycle
   } swm_status_type;

endpackage

// ----- rtl/sliding_window_median.sv -----
`timescale 1ns / 1ps
// Sliding window lower median filter. Each accepted sample replaces the oldest
// one in a window of W samples (W from the window size register, zero taken as
// one, values above WINDOW_MAX saturated). Once W samples have arrived, each
// sample yields the lower median, the element of zero-based rank (W-1)/2 in
// sorted order; before that no result is produced. Writing the window size
// restarts the fill. One sample at a time is processed; the sorted store is a
// single-port-write RAM, and a sample's time is set by the insertion walk over
// that RAM, by the search and gap-closing walks once the window is full, and by
// any wait for a result while the output register is still held by rsp_stall.
// A finished result waits in an output register while the next sample is taken.
// Depends on swm_pkg, swm_ctrl, swm_datapath and swm_ram.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_WIDTH-1:0]           csr_window_size
);

   swm_cmd_type    cmd;
   swm_status_type status;

   // Sequencer.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Stores, counters and output register.
   swm_datapath #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .csr_window_size (csr_window_size),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_median      (rsp_median),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ----- rtl/swm_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the sliding window median filter: steps one sample through
// removal, insertion and median read. Depends on swm_pkg.
module swm_ctrl
   import swm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  swm_status_type status,
   output swm_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RM_RD    = 4'd1;
   localparam logic [3:0] S_RM_CMP   = 4'd2;
   localparam logic [3:0] S_SH_RD    = 4'd3;
   localparam logic [3:0] S_SH_WR    = 4'd4;
   localparam logic [3:0] S_INS_INIT = 4'd5;
   localparam logic [3:0] S_INS_RD   = 4'd6;
   localparam logic [3:0] S_INS_CMP  = 4'd7;
   localparam logic [3:0] S_INS_PUT  = 4'd8;
   localparam logic [3:0] S_WRAP     = 4'd9;
   localparam logic [3:0] S_MED      = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       idle;

   assign idle      = (state_ff == S_IDLE);
   assign csr_ready = idle;
   // A pending register write takes precedence over a new sample.
   assign req_stall = !idle || csr_valid;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_IDX;
      unique case (state_ff)
         S_IDLE: begin
            cmd.cfg_wr = csr_valid;
            if (req_valid && !csr_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.full ? S_RM_RD : S_INS_INIT;
            end
         end
         // Search the sorted store for the oldest sample.
         S_RM_RD: begin
            cmd.rd_sel = RD_IDX;
            state_in   = S_RM_CMP;
         end
         S_RM_CMP: begin
            if (status.hit) begin
               state_in = S_SH_RD;
            end else if (status.idx_last) begin
               state_in = S_WRAP;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RM_RD;
            end
         end
         // Close the gap left by the removed sample.
         S_SH_RD: begin
            if (status.idx_last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_INS_INIT;
            end else begin
               cmd.rd_sel = RD_IDX_NEXT;
               state_in   = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_SH_RD;
         end
         // Walk down from the top, moving larger samples up by one.
         S_INS_INIT: begin
            cmd.idx_load_count = 1'b1;
            state_in           = S_INS_RD;
         end
         S_INS_RD: begin
            if (status.idx_zero) begin
               state_in = S_INS_PUT;
            end else begin
               cmd.rd_sel = RD_IDX_PREV;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.greater) begin
               cmd.wr_en   = 1'b1;
               cmd.idx_dec = 1'b1;
               state_in    = S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_key    = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = S_WRAP;
         end
         // Store the sample in arrival order and fetch the median if full.
         S_WRAP: begin
            cmd.ring_wr = 1'b1;
            cmd.rd_sel  = RD_RANK;
            state_in    = status.full ? S_MED : S_IDLE;
         end
         S_MED: begin
            cmd.rd_sel = RD_RANK;
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/swm_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the sliding window median filter: ring and sorted stores,
// counters, comparators and the output register. Depends on swm_pkg, swm_ram.
module swm_datapath
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [CSR_WIDTH-1:0]           csr_window_size,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median,
   input  swm_cmd_type                    cmd,
   output swm_status_type                 status
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int EW = (CW > CSR_WIDTH) ? CW : CSR_WIDTH;

   logic [CW-1:0]                  weff_ff;
   logic [CW-1:0]                  count_ff;
   logic [AW-1:0]                  ptr_ff;
   logic [CW-1:0]                  idx_ff;
   logic signed [SAMPLE_WIDTH-1:0] key_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median_ff;

   logic [EW-1:0]           csr_ext;
   logic [CW-1:0]           weff_in;
   logic [CW-1:0]           rank;
   logic [CW-1:0]           idx_next;
   logic [CW-1:0]           idx_prev;
   logic [CW-1:0]           rd_sel_addr;
   logic [CW-1:0]           ptr_next;
   logic [SAMPLE_WIDTH-1:0] sorted_rd;
   logic [SAMPLE_WIDTH-1:0] sorted_wr;
   logic [SAMPLE_WIDTH-1:0] ring_rd;

   // Effective window: zero means one, sizes above the store depth saturate.
   assign csr_ext = EW'(csr_window_size);
   always_comb begin
      if (csr_ext == '0) begin
         weff_in = CW'(1);
      end else if (csr_ext > EW'(WINDOW_MAX)) begin
         weff_in = CW'(WINDOW_MAX);
      end else begin
         weff_in = csr_ext[CW-1:0];
      end
   end

   // Lower median sits at zero-based rank (W - 1) / 2.
   assign rank     = (weff_ff - CW'(1)) >> 1;
   assign idx_next = idx_ff + CW'(1);
   assign idx_prev = idx_ff - CW'(1);
   assign ptr_next = CW'(ptr_ff) + CW'(1);

   // Sorted store read address.
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:      rd_sel_addr = idx_ff;
         RD_IDX_NEXT: rd_sel_addr = idx_next;
         RD_IDX_PREV: rd_sel_addr = idx_prev;
         default:     rd_sel_addr = rank;
      endcase
   end

   assign sorted_wr = cmd.wr_key ? key_ff : sorted_rd;

   swm_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_sorted (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (sorted_wr),
      .rd_addr (rd_sel_addr[AW-1:0]),
      .rd_data (sorted_rd)
   );

   // The ring is always read at its pointer, so the oldest sample is ready
   // on the registered read port in the cycle after the pointer settles.
   swm_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.ring_wr),
      .wr_addr (ptr_ff),
      .wr_data (key_ff),
      .rd_addr (ptr_ff),
      .rd_data (ring_rd)
   );

   // Status back to the controller.
   assign status.full     = (count_ff == weff_ff);
   assign status.hit      = (sorted_rd == ring_rd);
   assign status.idx_last = (idx_next >= count_ff);
   assign status.idx_zero = (idx_ff == '0);
   assign status.greater  = ($signed(sorted_rd) > key_ff);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   // Control registers: window size, fill count, ring pointer, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         weff_ff      <= CW'(1);
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_wr) begin
            weff_ff  <= weff_in;
            count_ff <= '0;
            ptr_ff   <= '0;
         end else begin
            if (cmd.count_inc) begin
               count_ff <= count_ff + CW'(1);
            end else if (cmd.count_dec) begin
               count_ff <= count_ff - CW'(1);
            end
            if (cmd.ring_wr) begin
               ptr_ff <= (ptr_next == weff_ff) ? '0 : ptr_next[AW-1:0];
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: sample, walk index and result.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= req_sample;
         idx_ff <= '0;
      end else if (cmd.idx_load_count) begin
         idx_ff <= count_ff;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_next;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_prev;
      end
      if (cmd.load_rsp) begin
         rsp_median_ff <= $signed(sorted_rd);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

// ----- tb/sliding_window_median_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window lower median filter.
// Depends on swm_pkg and sliding_window_median; a scoreboard class predicts each median.
module sliding_window_median_tb;
   import swm_pkg::*;

   localparam int WMAX = 64;
   localparam int SW = 32;
   // Worst per-sample processing time of the block plus some margin.
   localparam int DRAIN = 4 * WMAX + 24;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 800;
   localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SW-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SW-1:0] rsp_median;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_WIDTH-1:0] csr_window_size = '0;

   int cycles = 0;
   int random_sent = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   // Tracks the window contents and queues the median each sample should produce.
   class median_scoreboard;
      bit signed [SW-1:0] ring [WMAX];
      bit signed [SW-1:0] ordered [WMAX];
      int unsigned fill;
      int unsigned slot;
      bit [CSR_WIDTH-1:0] wsize;
      bit signed [SW-1:0] expected_medians [$];
      int mismatches;

      function new();
         wsize = 1;
         fill = 0;
         slot = 0;
         mismatches = 0;
      endfunction

      // Effective window length: zero acts as one, large values saturate.
      function int unsigned span();
         if (wsize == 0) return 1;
         if (wsize > WMAX) return WMAX;
         return wsize;
      endfunction

      // A new window size restarts the fill from empty.
      function void write_window(bit [CSR_WIDTH-1:0] ws);
         wsize = ws;
         fill = 0;
         slot = 0;
      endfunction

      function void note_sample(bit signed [SW-1:0] s);
         int unsigned w;
         int unsigned cnt;
         int unsigned pos;
         bit found;
         w = span();
         cnt = fill;
         if (slot >= w) slot = 0;
         if (cnt > w) cnt = w;
         // Drop one copy of the oldest sample once the window is full.
         if (cnt == w) begin
            found = 1'b0;
            for (int i = 0; i < cnt && !found; i++) begin
               if (ordered[i] == ring[slot]) begin
                  for (int j = i; j + 1 < cnt; j++) ordered[j] = ordered[j + 1];
                  found = 1'b1;
               end
            end
            if (found) cnt--;
         end
         // Insert the new sample in ascending position.
         if (cnt < w) begin
            pos = cnt;
            while (pos > 0 && ordered[pos - 1] > s) begin
               ordered[pos] = ordered[pos - 1];
               pos--;
            end
            ordered[pos] = s;
            cnt++;
         end
         ring[slot] = s;
         slot++;
         if (slot >= w) slot = 0;
         fill = cnt;
         if (cnt == w)
            expected_medians.insert(expected_medians.size(), ordered[(w + 1) / 2 - 1]);
      endfunction

      function void check_median(logic signed [SW-1:0] got);
         bit signed [SW-1:0] want;
         if (expected_medians.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected median %0d with none pending", $realtime, got);
         end else begin
            want = expected_medians.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: median mismatch, expected %0d, got %0d",
                           $realtime, want, got);
            end
         end
      endfunction

      function int pending();
         return expected_medians.size();
      endfunction
   endclass

   median_scoreboard sb;

   sliding_window_median #(
      .WINDOW_MAX(WMAX),
      .SAMPLE_WIDTH(SW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median(rsp_median),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_window_size(csr_window_size)
   );

   always #5 clock = ~clock;

   // Cycle counter with a hard timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("sliding_window_median verification failed");
         $finish;
      end
   end

   // Check every median transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_median(rsp_median);
   end

   // Result side: stall for a random number of cycles after each transfer.
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         n = rsp_quiet ? 0 : $urandom_range(0, 12);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Present one sample after a random gap and wait for its transfer.
   task automatic send_sample(input logic signed [SW-1:0] value);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      sb.note_sample(value);
   endtask

   // Write the window size once the block has drained.
   task automatic set_window(input logic [CSR_WIDTH-1:0] ws);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // A sample that gives no median may still be in flight.
      repeat (DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_window_size <= ws;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_window(ws);
   endtask

   // Mix of full-range values, clustered values that repeat, and extremes.
   function automatic logic signed [SW-1:0] draw_sample();
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 6)) - 3;
         1: begin
            case ($urandom_range(0, 3))
               0: return SMIN;
               1: return SMAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   initial begin
      int phase;
      int items;
      logic [CSR_WIDTH-1:0] ws;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and bit patterns at the reset window of one.
      send_sample(SMIN);
      send_sample(SMAX);
      send_sample('0);
      send_sample('1);
      send_sample(1);
      send_sample(32'h5555_5555);
      send_sample(32'hAAAA_AAAA);
      // A window size of zero behaves as a window of one.
      set_window(0);
      send_sample(5);
      send_sample(-5);
      // Equal samples: only one copy of the oldest leaves the window.
      set_window(3);
      send_sample(7);
      send_sample(7);
      send_sample(7);
      send_sample(-2);
      send_sample(7);
      send_sample(-2);
      // Even window takes the lower of the two middle values.
      set_window(4);
      send_sample(10);
      send_sample(-20);
      send_sample(30);
      send_sample(-40);
      send_sample(SMAX);
      send_sample(SMIN);
      set_window(2);
      send_sample(SMIN);
      send_sample(SMAX);
      send_sample(SMIN);

      // Random phases, each with its own window size and idling pattern.
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase)
            0: ws = CSR_WIDTH'(WMAX);
            1: ws = '1;
            2: ws = '0;
            default: begin
               case ($urandom_range(0, 15))
                  0: ws = CSR_WIDTH'($urandom_range(WMAX + 1, (1 << CSR_WIDTH) - 1));
                  1: ws = CSR_WIDTH'($urandom_range(9, WMAX));
                  default: ws = CSR_WIDTH'($urandom_range(1, 8));
               endcase
            end
         endcase
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         set_window(ws);
         items = sb.span() + $urandom_range(4, 24);
         repeat (items) begin
            send_sample(draw_sample());
            random_sent++;
         end
         phase++;
      end
      req_valid <= 1'b0;

      // Drain the outstanding medians, then allow for trailing activity.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("sliding_window_median verification clean");
      end else begin
         $display("sliding_window_median verification failed");
      end
      $finish;
   end

endmodule

// ----- sliding_window_median.f -----
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_ctrl.sv
rtl/swm_datapath.sv
rtl/sliding_window_median.sv
tb/sliding_window_median_tb.sv
